FILE: sv/leosi_pkg.sv
`timescale 1ns / 1ps

package leosi_pkg;

  // Fixed field geometry of the site channels.
  localparam int NUM_DIMS           = 4;
  localparam int COORD_BITS         = 10;
  localparam int SITE_W             = 24;
  localparam int MAX_EXTENT_DEFAULT = 64;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int DIMS_W     = 3;
  localparam int EXT_REG_W  = 7;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_3    = 3'd4;

  // Register values after reset.
  localparam logic [DIMS_W-1:0]    DIMS_RESET   = 3'd4;
  localparam logic [EXT_REG_W-1:0] EXTENT_RESET = 7'd4;

  // One input item: a global site.
  typedef struct packed {
    logic [COORD_BITS-1:0] coord_0;
    logic [COORD_BITS-1:0] coord_1;
    logic [COORD_BITS-1:0] coord_2;
    logic [COORD_BITS-1:0] coord_3;
  } site_in_t;

  // One result item: node-local index and node-grid coordinates.
  typedef struct packed {
    logic [SITE_W-1:0]     site_index;
    logic [COORD_BITS-1:0] block_0;
    logic [COORD_BITS-1:0] block_1;
    logic [COORD_BITS-1:0] block_2;
    logic [COORD_BITS-1:0] block_3;
  } site_out_t;

  // Parity bits that travel with an item through the rank cells.
  typedef struct packed {
    logic gpar;    // parity of the global coordinate sum
    logic lpar;    // parity of the local coordinate sum
    logic lowpar;  // parity of the local coordinates of the dimensions done so far
  } par_t;

  // Running counts of the rank cells, all modulo 2**SITE_W.
  typedef struct packed {
    logic [SITE_W-1:0] ev;  // even-sum sites of the sub-box below this dimension
    logic [SITE_W-1:0] od;  // odd-sum sites of the same sub-box
    logic [SITE_W-1:0] eb;  // even-sum positions before the site
    logic [SITE_W-1:0] ob;  // odd-sum positions before the site
  } cnt_t;

endpackage

FILE: sv/leosi_div_cell.sv
`timescale 1ns / 1ps

module leosi_div_cell
  import leosi_pkg::*;
#(
  parameter int MAX_EXTENT = MAX_EXTENT_DEFAULT
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  output logic                                       ready_o,
  input  logic [NUM_DIMS-1:0][COORD_BITS-1:0]        num_i,
  input  logic [NUM_DIMS-1:0][$clog2(MAX_EXTENT)-1:0] rem_i,
  input  logic [NUM_DIMS-1:0][$clog2(MAX_EXTENT+1)-1:0] ext_i,
  input  logic                                       gpar_i,
  output logic                                       valid_o,
  input  logic                                       ready_i,
  output logic [NUM_DIMS-1:0][COORD_BITS-1:0]        num_o,
  output logic [NUM_DIMS-1:0][$clog2(MAX_EXTENT)-1:0] rem_o,
  output logic [NUM_DIMS-1:0][$clog2(MAX_EXTENT+1)-1:0] ext_o,
  output logic                                       gpar_o
);

  localparam int LOC_W = $clog2(MAX_EXTENT);
  localparam int EXT_W = $clog2(MAX_EXTENT + 1);

  logic                                valid_q;
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] num_d, num_q;
  logic [NUM_DIMS-1:0][LOC_W-1:0]      rem_d, rem_q;
  logic [NUM_DIMS-1:0][EXT_W-1:0]      ext_q;
  logic                                gpar_q;
  logic [NUM_DIMS-1:0][LOC_W:0]        trial;
  logic [NUM_DIMS-1:0][LOC_W:0]        ext_x;
  logic [NUM_DIMS-1:0]                 fits;

  // The slice takes a new transfer whenever it is empty or its content moves on.
  assign ready_o = !valid_q || ready_i;

  // One restoring division step per lane: bring down the next dividend bit and
  // subtract the extent if it fits. The quotient bit shifts in at the bottom.
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      trial[d] = {rem_i[d], num_i[d][COORD_BITS-1]};
      ext_x[d] = (LOC_W + 1)'(ext_i[d]);
      fits[d]  = trial[d] >= ext_x[d];
      rem_d[d] = fits[d] ? LOC_W'(trial[d] - ext_x[d]) : trial[d][LOC_W-1:0];
      num_d[d] = {num_i[d][COORD_BITS-2:0], fits[d]};
    end
  end

  // Slice valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Slice payload.
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      ext_q  <= ext_i;
      gpar_q <= gpar_i;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign ext_o   = ext_q;
  assign gpar_o  = gpar_q;

endmodule

FILE: sv/leosi_rank_cell.sv
`timescale 1ns / 1ps

module leosi_rank_cell
  import leosi_pkg::*;
#(
  parameter int MAX_EXTENT = MAX_EXTENT_DEFAULT,
  parameter int DIM        = 0
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  logic [NUM_DIMS-1:0][COORD_BITS-1:0]           blk_i,
  input  logic [NUM_DIMS-1:0][$clog2(MAX_EXTENT)-1:0]   loc_i,
  input  logic [NUM_DIMS-1:0][$clog2(MAX_EXTENT+1)-1:0] ext_i,
  input  par_t                                          par_i,
  input  cnt_t                                          cnt_i,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output logic [NUM_DIMS-1:0][COORD_BITS-1:0]           blk_o,
  output logic [NUM_DIMS-1:0][$clog2(MAX_EXTENT)-1:0]   loc_o,
  output logic [NUM_DIMS-1:0][$clog2(MAX_EXTENT+1)-1:0] ext_o,
  output par_t                                          par_o,
  output cnt_t                                          cnt_o
);

  localparam int LOC_W = $clog2(MAX_EXTENT);
  localparam int EXT_W = $clog2(MAX_EXTENT + 1);

  // Product stage registers.
  logic                                a_valid_q;
  logic                                a_ready;
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] a_blk_q;
  logic [NUM_DIMS-1:0][LOC_W-1:0]      a_loc_q;
  logic [NUM_DIMS-1:0][EXT_W-1:0]      a_ext_q;
  par_t                                a_par_d, a_par_q;
  logic [SITE_W-1:0]                   a_eb_q, a_ob_q;
  logic [SITE_W-1:0]                   p_ae_q, p_bo_q, p_be_q, p_ao_q;
  logic [SITE_W-1:0]                   p_he_q, p_lo_q, p_le_q, p_ho_q;

  // Sum stage registers.
  logic                                b_valid_q;
  logic                                b_ready;
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] b_blk_q;
  logic [NUM_DIMS-1:0][LOC_W-1:0]      b_loc_q;
  logic [NUM_DIMS-1:0][EXT_W-1:0]      b_ext_q;
  par_t                                b_par_q;
  cnt_t                                b_cnt_d, b_cnt_q;

  // Half counts of this dimension.
  logic [LOC_W-1:0] x;
  logic [EXT_W-1:0] e;
  logic [LOC_W:0]   x_inc;
  logic [EXT_W:0]   e_inc;
  logic [LOC_W-1:0] hx, lx, ax, bx;
  logic [EXT_W-1:0] he, le;
  logic             upper_odd;

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  // Split this dimension's local coordinate and extent into the number of even
  // and odd values below them. The parity of the dimensions above this one picks
  // which sub-box count pairs with which half.
  always_comb begin
    x         = loc_i[DIM];
    e         = ext_i[DIM];
    x_inc     = (LOC_W + 1)'(x) + 1'b1;
    e_inc     = (EXT_W + 1)'(e) + 1'b1;
    hx        = x_inc[LOC_W:1];
    lx        = x >> 1;
    he        = e_inc[EXT_W:1];
    le        = e >> 1;
    upper_odd = par_i.lpar ^ par_i.lowpar ^ x[0];
    ax        = upper_odd ? lx : hx;
    bx        = upper_odd ? hx : lx;
    a_par_d        = par_i;
    a_par_d.lowpar = par_i.lowpar ^ x[0];
  end

  // Product stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  // Product stage payload: eight narrow-by-count multiplications, modulo 2**SITE_W.
  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_blk_q <= blk_i;
      a_loc_q <= loc_i;
      a_ext_q <= ext_i;
      a_par_q <= a_par_d;
      a_eb_q  <= cnt_i.eb;
      a_ob_q  <= cnt_i.ob;
      p_ae_q  <= SITE_W'(ax) * cnt_i.ev;
      p_bo_q  <= SITE_W'(bx) * cnt_i.od;
      p_be_q  <= SITE_W'(bx) * cnt_i.ev;
      p_ao_q  <= SITE_W'(ax) * cnt_i.od;
      p_he_q  <= SITE_W'(he) * cnt_i.ev;
      p_lo_q  <= SITE_W'(le) * cnt_i.od;
      p_le_q  <= SITE_W'(le) * cnt_i.ev;
      p_ho_q  <= SITE_W'(he) * cnt_i.od;
    end
  end

  // Accumulate the positions before the site and grow the sub-box by this dimension.
  always_comb begin
    b_cnt_d.eb = a_eb_q + p_ae_q + p_bo_q;
    b_cnt_d.ob = a_ob_q + p_be_q + p_ao_q;
    b_cnt_d.ev = p_he_q + p_lo_q;
    b_cnt_d.od = p_le_q + p_ho_q;
  end

  // Sum stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  // Sum stage payload.
  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      b_blk_q <= a_blk_q;
      b_loc_q <= a_loc_q;
      b_ext_q <= a_ext_q;
      b_par_q <= a_par_q;
      b_cnt_q <= b_cnt_d;
    end
  end

  assign valid_o = b_valid_q;
  assign blk_o   = b_blk_q;
  assign loc_o   = b_loc_q;
  assign ext_o   = b_ext_q;
  assign par_o   = b_par_q;
  assign cnt_o   = b_cnt_q;

endmodule

FILE: sv/lattice_even_odd_site_index_unit.sv
// Registered path: input slice, divider cells, both halves of each rank cell, output slice.
// Throughput: one site per cycle unless stalled; every divider cell and both halves of
// every rank cell are a register slice with its own valid bit, so stalls only fill empty
// slices. Reset (asynchronous, active low): dims_in_use and all extents return to 4 and
// all valid bits clear. cfg_ready_o is always high; a write takes effect on the next cycle.
`timescale 1ns / 1ps

module lattice_even_odd_site_index_unit
  import leosi_pkg::*;
#(
  parameter int MAX_EXTENT = MAX_EXTENT_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  site_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output site_out_t             out_data_o
);

  localparam int LOC_W = $clog2(MAX_EXTENT);
  localparam int EXT_W = $clog2(MAX_EXTENT + 1);

  // Configuration registers.
  logic [DIMS_W-1:0]                  dims_q;
  logic [NUM_DIMS-1:0][EXT_REG_W-1:0] extent_q;

  // Input slice.
  logic                                s0_valid_q;
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] coord_d, s0_coord_q;
  logic [NUM_DIMS-1:0][EXT_W-1:0]      ext_d, s0_ext_q;
  logic                                gpar_d, s0_gpar_q;

  // Divider chain, entry k feeds cell k.
  logic                                div_valid [COORD_BITS+1];
  logic                                div_ready [COORD_BITS+1];
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] div_num   [COORD_BITS+1];
  logic [NUM_DIMS-1:0][LOC_W-1:0]      div_rem   [COORD_BITS+1];
  logic [NUM_DIMS-1:0][EXT_W-1:0]      div_ext   [COORD_BITS+1];
  logic                                div_gpar  [COORD_BITS+1];

  // Rank chain, entry d feeds the cell of dimension d.
  logic                                rk_valid [NUM_DIMS+1];
  logic                                rk_ready [NUM_DIMS+1];
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] rk_blk   [NUM_DIMS+1];
  logic [NUM_DIMS-1:0][LOC_W-1:0]      rk_loc   [NUM_DIMS+1];
  logic [NUM_DIMS-1:0][EXT_W-1:0]      rk_ext   [NUM_DIMS+1];
  par_t                                rk_par   [NUM_DIMS+1];
  cnt_t                                rk_cnt   [NUM_DIMS+1];
  logic                                lpar;

  // Output slice.
  logic              out_valid_q;
  site_out_t         out_data_d, out_data_q;
  logic [SITE_W-1:0] rank, other;

  // Configuration writes; indexes past the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIMS_RESET;
      for (int d = 0; d < NUM_DIMS; d++) begin
        extent_q[d] <= EXTENT_RESET;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DIMS_IN_USE: dims_q      <= cfg_data_i[DIMS_W-1:0];
        REG_EXTENT_0:    extent_q[0] <= cfg_data_i;
        REG_EXTENT_1:    extent_q[1] <= cfg_data_i;
        REG_EXTENT_2:    extent_q[2] <= cfg_data_i;
        REG_EXTENT_3:    extent_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective extents: zero reads as one, large values saturate, and dimensions
  // beyond the count in use have extent one.
  always_comb begin
    int nd;
    int ev_int;
    nd = int'(dims_q);
    if (nd == 0) nd = 1;
    if (nd > NUM_DIMS) nd = NUM_DIMS;
    for (int d = 0; d < NUM_DIMS; d++) begin
      ev_int = int'(extent_q[d]);
      if (ev_int == 0) ev_int = 1;
      if (ev_int > MAX_EXTENT) ev_int = MAX_EXTENT;
      if (d >= nd) ev_int = 1;
      ext_d[d] = EXT_W'(ev_int);
    end
  end

  // Unpack the input site and take the global parity.
  assign coord_d[0] = in_data_i.coord_0;
  assign coord_d[1] = in_data_i.coord_1;
  assign coord_d[2] = in_data_i.coord_2;
  assign coord_d[3] = in_data_i.coord_3;
  assign gpar_d     = coord_d[0][0] ^ coord_d[1][0] ^ coord_d[2][0] ^ coord_d[3][0];

  assign in_ready_o = !s0_valid_q || div_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      s0_coord_q <= coord_d;
      s0_ext_q   <= ext_d;
      s0_gpar_q  <= gpar_d;
    end
  end

  // Divider chain: one quotient bit per cell, all lanes side by side.
  assign div_valid[0] = s0_valid_q;
  assign div_num[0]   = s0_coord_q;
  assign div_rem[0]   = '0;
  assign div_ext[0]   = s0_ext_q;
  assign div_gpar[0]  = s0_gpar_q;

  for (genvar k = 0; k < COORD_BITS; k++) begin : g_div
    leosi_div_cell #(
      .MAX_EXTENT(MAX_EXTENT)
    ) u_div_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(div_valid[k]),
      .ready_o(div_ready[k]),
      .num_i  (div_num[k]),
      .rem_i  (div_rem[k]),
      .ext_i  (div_ext[k]),
      .gpar_i (div_gpar[k]),
      .valid_o(div_valid[k+1]),
      .ready_i(div_ready[k+1]),
      .num_o  (div_num[k+1]),
      .rem_o  (div_rem[k+1]),
      .ext_o  (div_ext[k+1]),
      .gpar_o (div_gpar[k+1])
    );
  end

  // Local parity of the site, known once all remainders are out.
  always_comb begin
    lpar = 1'b0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      lpar = lpar ^ div_rem[COORD_BITS][d][0];
    end
  end

  // Rank chain: dimension 0 first, starting from an empty sub-box of one even site.
  assign rk_valid[0]         = div_valid[COORD_BITS];
  assign div_ready[COORD_BITS] = rk_ready[0];
  assign rk_blk[0]           = div_num[COORD_BITS];
  assign rk_loc[0]           = div_rem[COORD_BITS];
  assign rk_ext[0]           = div_ext[COORD_BITS];
  assign rk_par[0]           = '{gpar: div_gpar[COORD_BITS], lpar: lpar, lowpar: 1'b0};
  assign rk_cnt[0]           = '{ev: SITE_W'(1), od: '0, eb: '0, ob: '0};

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_rank
    leosi_rank_cell #(
      .MAX_EXTENT(MAX_EXTENT),
      .DIM       (d)
    ) u_rank_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(rk_valid[d]),
      .ready_o(rk_ready[d]),
      .blk_i  (rk_blk[d]),
      .loc_i  (rk_loc[d]),
      .ext_i  (rk_ext[d]),
      .par_i  (rk_par[d]),
      .cnt_i  (rk_cnt[d]),
      .valid_o(rk_valid[d+1]),
      .ready_i(rk_ready[d+1]),
      .blk_o  (rk_blk[d+1]),
      .loc_o  (rk_loc[d+1]),
      .ext_o  (rk_ext[d+1]),
      .par_o  (rk_par[d+1]),
      .cnt_o  (rk_cnt[d+1])
    );
  end

  // Final index: even-local sites rank among even positions, odd ones among odd
  // positions; an odd global sum moves the site behind the other half of the node.
  always_comb begin
    rank  = rk_par[NUM_DIMS].lpar ? rk_cnt[NUM_DIMS].ob : rk_cnt[NUM_DIMS].eb;
    other = rk_par[NUM_DIMS].lpar ? rk_cnt[NUM_DIMS].ev : rk_cnt[NUM_DIMS].od;
    out_data_d.site_index = rank + (rk_par[NUM_DIMS].gpar ? other : '0);
    out_data_d.block_0    = rk_blk[NUM_DIMS][0];
    out_data_d.block_1    = rk_blk[NUM_DIMS][1];
    out_data_d.block_2    = rk_blk[NUM_DIMS][2];
    out_data_d.block_3    = rk_blk[NUM_DIMS][3];
  end

  // Output slice.
  assign rk_ready[NUM_DIMS] = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rk_ready[NUM_DIMS]) begin
      out_valid_q <= rk_valid[NUM_DIMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rk_ready[NUM_DIMS]) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // With the output slice empty, every slice upstream can move, so input is taken.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready while the output slice is empty");

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_chk
    // Effective extents stay in the legal range whatever the registers hold.
    a_ext_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
      s0_valid_q |-> (s0_ext_q[d] != '0) && (s0_ext_q[d] <= EXT_W'(MAX_EXTENT)))
      else $error("effective extent out of range");

    // The divider leaves each local coordinate below its extent.
    a_loc_below_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
      rk_valid[NUM_DIMS] |->
        ((EXT_W + 1)'(rk_loc[NUM_DIMS][d]) < (EXT_W + 1)'(rk_ext[NUM_DIMS][d])))
      else $error("local coordinate not below its extent");
  end
`endif

endmodule

FILE: tb/sv/lattice_even_odd_site_index_unit_tb.sv
`timescale 1ns / 1ps

module lattice_even_odd_site_index_unit_tb;
  import leosi_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int EXTENT_CAP   = MAX_EXTENT_DEFAULT;
  localparam int PHASE_SITES  = 80;

  // Indexes past the last register; writes there must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int                   COORD_MAX    = (1 << COORD_BITS) - 1;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  site_in_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  site_out_t             out_data_o;

  // Shadow copy of the configuration registers.
  logic [DIMS_W-1:0]    dims_shadow;
  logic [EXT_REG_W-1:0] extent_shadow [NUM_DIMS];

  // Expected results in transfer order.
  site_out_t expected_sites [$];
  site_out_t oldest_site;

  int  fail_cnt     = 0;
  int  sites_sent   = 0;
  int  sites_seen   = 0;
  int  reg_writes   = 0;
  int  setups       = 0;
  int  cycle_cnt    = 0;
  bit  in_gap_en    = 1'b1;
  bit  out_stall_en = 1'b1;

  lattice_even_odd_site_index_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog: a run that has not finished by the limit has hung.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Effective extent of one dimension under the current shadow registers.
  function automatic longint unsigned eff_extent(int d);
    longint unsigned nd;
    longint unsigned e;
    nd = dims_shadow;
    if (nd == 0) nd = 1;
    if (nd > NUM_DIMS) nd = NUM_DIMS;
    if (d >= nd) return 1;
    e = extent_shadow[d];
    if (e == 0) e = 1;
    if (e > EXTENT_CAP) e = EXTENT_CAP;
    return e;
  endfunction

  // Node-grid coordinates and checkerboard rank of one global site.
  function automatic site_out_t predict_site(site_in_t s);
    longint unsigned coord [NUM_DIMS];
    longint unsigned ext [NUM_DIMS];
    longint unsigned loc [NUM_DIMS];
    longint unsigned blk [NUM_DIMS];
    longint unsigned ev [NUM_DIMS+1];
    longint unsigned od [NUM_DIMS+1];
    longint unsigned gsum, lsum, lex, even_before, upper, rank, other, idx, hi, lo;
    int d;
    site_out_t r;
    coord[0] = s.coord_0;
    coord[1] = s.coord_1;
    coord[2] = s.coord_2;
    coord[3] = s.coord_3;
    gsum = 0;
    lsum = 0;
    for (d = 0; d < NUM_DIMS; d++) begin
      ext[d] = eff_extent(d);
      loc[d] = coord[d] % ext[d];
      blk[d] = coord[d] / ext[d];
      gsum += coord[d];
      lsum += loc[d];
    end
    // Even and odd site counts of the sub-box below each dimension.
    ev[0] = 1;
    od[0] = 0;
    for (d = 0; d < NUM_DIMS; d++) begin
      hi = (ext[d] + 1) / 2;
      lo = ext[d] / 2;
      ev[d+1] = hi * ev[d] + lo * od[d];
      od[d+1] = lo * ev[d] + hi * od[d];
    end
    // Walk from the slowest dimension, counting even-sum positions ahead of the site.
    lex = 0;
    even_before = 0;
    upper = 0;
    for (d = NUM_DIMS - 1; d >= 0; d--) begin
      hi = (loc[d] + 1) / 2;
      lo = loc[d] / 2;
      if (upper[0] == 1'b0) even_before += hi * ev[d] + lo * od[d];
      else even_before += lo * ev[d] + hi * od[d];
      upper += loc[d];
      lex = lex * ext[d] + loc[d];
    end
    if (lsum[0] == 1'b0) begin
      rank  = even_before;
      other = od[NUM_DIMS];
    end else begin
      rank  = lex - even_before;
      other = ev[NUM_DIMS];
    end
    idx = rank;
    if (gsum[0]) idx += other;
    r.site_index = idx[SITE_W-1:0];
    r.block_0    = blk[0][COORD_BITS-1:0];
    r.block_1    = blk[1][COORD_BITS-1:0];
    r.block_2    = blk[2][COORD_BITS-1:0];
    r.block_3    = blk[3][COORD_BITS-1:0];
    return r;
  endfunction

  function automatic site_in_t make_site(int c0, int c1, int c2, int c3);
    site_in_t s;
    s.coord_0 = c0[COORD_BITS-1:0];
    s.coord_1 = c1[COORD_BITS-1:0];
    s.coord_2 = c2[COORD_BITS-1:0];
    s.coord_3 = c3[COORD_BITS-1:0];
    return s;
  endfunction

  // Idle stretch length: mostly short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Coordinates biased toward the field extremes and the edges of a node block.
  function automatic int pick_coord(int d);
    longint unsigned e;
    int c;
    e = eff_extent(d);
    case ($urandom_range(0, 3))
      0: c = $urandom_range(0, 1) ? int'(COORD_MAX) : 0;
      1: begin
        c = int'(e) * $urandom_range(0, int'(COORD_MAX) / int'(e));
        if ($urandom_range(0, 1)) c += int'(e) - 1;
        if (c > int'(COORD_MAX)) c = int'(COORD_MAX);
      end
      default: c = $urandom_range(0, int'(COORD_MAX));
    endcase
    return c;
  endfunction

  // Receiver side: ready drops for random stretches while stalls are enabled.
  initial begin : out_ready_gen
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (out_stall_en && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        hold = pick_idle() - 1;
      end else begin
        out_ready_i <= 1'b1;
        hold = $urandom_range(0, 7);
      end
    end
  end

  task automatic check_field(input string name, input logic [SITE_W-1:0] want,
                             input logic [SITE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Each result transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      sites_seen++;
      if (expected_sites.size() == 0) begin
        $error("result transfer with no site outstanding");
        fail_cnt++;
      end else begin
        oldest_site = expected_sites.pop_front();
        check_field("site_index", oldest_site.site_index, out_data_o.site_index);
        check_field("block_0", SITE_W'(oldest_site.block_0), SITE_W'(out_data_o.block_0));
        check_field("block_1", SITE_W'(oldest_site.block_1), SITE_W'(out_data_o.block_1));
        check_field("block_2", SITE_W'(oldest_site.block_2), SITE_W'(out_data_o.block_2));
        check_field("block_3", SITE_W'(oldest_site.block_3), SITE_W'(out_data_o.block_3));
      end
    end
  end

  // One input transfer, preceded by an optional idle gap.
  task automatic send_site(input site_in_t s);
    int gap;
    gap = (in_gap_en && $urandom_range(0, 2) == 0) ? pick_idle() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
    expected_sites.push_back(predict_site(s));
    sites_sent++;
  endtask

  task automatic send_random_sites(input int n);
    repeat (n) send_site(make_site(pick_coord(0), pick_coord(1), pick_coord(2),
                                   pick_coord(3)));
  endtask

  // Stop sending and wait until every outstanding site has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_sites.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx) inside
      REG_DIMS_IN_USE: dims_shadow = data[DIMS_W-1:0];
      REG_EXTENT_0, REG_EXTENT_1, REG_EXTENT_2, REG_EXTENT_3:
        extent_shadow[idx - REG_EXTENT_0] = data[EXT_REG_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup(input logic [CFG_DATA_W-1:0] dims, input logic [CFG_DATA_W-1:0] e0,
                       input logic [CFG_DATA_W-1:0] e1, input logic [CFG_DATA_W-1:0] e2,
                       input logic [CFG_DATA_W-1:0] e3);
    settle();
    write_register(REG_DIMS_IN_USE, dims);
    write_register(REG_EXTENT_0, e0);
    write_register(REG_EXTENT_1, e1);
    write_register(REG_EXTENT_2, e2);
    write_register(REG_EXTENT_3, e3);
    setups++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_extent();
    if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom_range(0, 127));
    return CFG_DATA_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dims();
    if ($urandom_range(0, 4) == 0) return CFG_DATA_W'($urandom_range(0, 127));
    return CFG_DATA_W'($urandom_range(1, NUM_DIMS));
  endfunction

  // Reset registers: four dimensions of extent four.
  task automatic test_reset_state();
    send_site(make_site(0, 0, 0, 0));
    send_site(make_site(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_site(make_site(1, 0, 0, 0));
    send_site(make_site(5, 2, 7, 1));
  endtask

  // Only dimension 0 in use: the others keep their full coordinate as block.
  task automatic test_unused_dims();
    setup(1, 5, 3, 6, 7);
    send_site(make_site(7, COORD_MAX, 1, 0));
    send_site(make_site(COORD_MAX, 0, 0, 1));
  endtask

  // Zero extent acts as one, extents above the cap saturate.
  task automatic test_extent_limits();
    setup(CFG_DATA_W'(NUM_DIMS), 0, 127, 64, 1);
    send_site(make_site(0, 63, 64, COORD_MAX));
    send_site(make_site(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_site(make_site(1, 127, 65, 3));
  endtask

  // A dimension count of zero acts as one; counts above the maximum saturate,
  // and bits above the register width are dropped.
  task automatic test_dims_saturation();
    setup(0, 3, 5, 2, 2);
    send_site(make_site(8, 9, 10, 11));
    send_site(make_site(COORD_MAX, 1, 2, 3));
    settle();
    write_register(REG_DIMS_IN_USE, 7'h7D);
    send_site(make_site(8, 9, 10, 11));
    send_site(make_site(2, 4, 1, COORD_MAX));
  endtask

  // Writes past the last register index change nothing.
  task automatic test_spare_indexes();
    logic [CFG_IDX_W-1:0] idx;
    setup(CFG_DATA_W'(NUM_DIMS), 2, 3, 2, 3);
    for (idx = REG_SPARE_LO; idx != REG_DIMS_IN_USE; idx++) write_register(idx, '1);
    send_site(make_site(3, 4, 5, 6));
    send_site(make_site(COORD_MAX, 1, COORD_MAX, 0));
  endtask

  // Random sites under a series of settings, the extremes first.
  task automatic test_random_sites();
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: setup(CFG_DATA_W'(NUM_DIMS), CFG_DATA_W'(EXTENT_CAP), CFG_DATA_W'(EXTENT_CAP),
                 CFG_DATA_W'(EXTENT_CAP), CFG_DATA_W'(EXTENT_CAP));
        1: setup(CFG_DATA_W'(NUM_DIMS), 1, 1, 1, 1);
        2: setup(1, pick_extent(), pick_extent(), pick_extent(), pick_extent());
        default: setup(pick_dims(), pick_extent(), pick_extent(), pick_extent(),
                       pick_extent());
      endcase
      if ($urandom_range(0, 1))
        write_register(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                       CFG_DATA_W'($urandom_range(0, 127)));
      in_gap_en    = (phase % 3) != 0;
      out_stall_en = (phase % 4) != 1;
      send_random_sites(PHASE_SITES);
    end
  endtask

  // The sender stops mid-stream until the block has returned every site.
  task automatic test_drain_pause();
    setup(CFG_DATA_W'(NUM_DIMS), pick_extent(), pick_extent(), pick_extent(),
          pick_extent());
    in_gap_en    = 1'b0;
    out_stall_en = 1'b1;
    send_random_sites(30);
    settle();
    in_gap_en = 1'b1;
    send_random_sites(30);
  endtask

  initial begin
    dims_shadow = DIMS_RESET;
    foreach (extent_shadow[d]) extent_shadow[d] = EXTENT_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_unused_dims();
    test_extent_limits();
    test_dims_saturation();
    test_spare_indexes();
    test_random_sites();
    test_drain_pause();

    // Let the pipeline empty, then watch a while for stray results.
    settle();
    out_stall_en = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_sites.size() != 0) begin
      $error("%0d sites never returned", expected_sites.size());
      fail_cnt++;
    end

    $display("Sent %0d sites and checked %0d results across %0d settings (%0d register writes).",
             sites_sent, sites_seen, setups, reg_writes);
    $display("Covered unused dimensions, zero and saturated extents, dimension-count limits,");
    $display("writes to unmapped indexes, and random idle gaps on both channels.");
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: lattice_even_odd_site_index_unit.f
sv/leosi_pkg.sv
sv/leosi_div_cell.sv
sv/leosi_rank_cell.sv
sv/lattice_even_odd_site_index_unit.sv
tb/sv/lattice_even_odd_site_index_unit_tb.sv
